// ----- hw/rtl/sgm_pkg.sv -----
// Shared constants, types and state codes of the Sobel gradient magnitude unit.
`timescale 1ns / 1ps

package sgm_pkg;

    // Line stores and column addressing
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int FILL_W    = ADDR_W + 1;
    localparam int LINE_W    = 16;

    // Field and register widths
    localparam int CFG_W  = 12;
    localparam int PIX_W  = 8;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 11;
    localparam int GRAD_W = 12;
    localparam int SUM_W  = 21;
    localparam int ROOT_W = 8;
    localparam int WUSE_W = (CFG_W > FILL_W) ? CFG_W + 1 : FILL_W + 1;

    // Configuration register indexes
    localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);
    localparam logic [CFG_W-1:0] MIN_DIM          = CFG_W'(3);
    localparam logic [ROOT_W-1:0] ROOT_MAX        = '1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_SQX  = 6'b000100,
        S_SQY  = 6'b001000,
        S_ROOT = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
    } t_root_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_root_rsp;

endpackage

// ----- hw/rtl/sgm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module sgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sgm_isqrt.sv -----
// Bit-serial integer square root, saturated to eight bits, one result bit per cycle.
`timescale 1ns / 1ps

module sgm_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgm_pkg::t_root_req i_req,
    output sgm_pkg::t_root_rsp o_rsp
);
    import sgm_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic                r_sat;
    logic [15:0]         r_sum;
    logic [ROOT_W-1:0]   r_m;
    logic [ROOT_W-1:0]   r_bit;
    logic [ROOT_W-1:0]   trial;
    logic [2*ROOT_W-1:0] trial_sq;

    assign trial    = r_m | r_bit;
    assign trial_sq = trial * trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sat <= |i_req.sum[SUM_W-1:16];
            r_sum <= i_req.sum[15:0];
            r_m   <= '0;
            r_bit <= {1'b1, {(ROOT_W-1){1'b0}}};
        end else if (r_busy) begin
            if (trial_sq <= r_sum) begin
                r_m <= trial;
            end
            r_bit <= r_bit >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_sat ? ROOT_MAX : r_m;

endmodule

// ----- hw/rtl/sobel_gradient_magnitude_unit.sv -----
// Sobel 3x3 gradient magnitude over a raster pixel stream, with both line stores in one RAM.
// An accepted interior word passes through READ, SQX, SQY, ROOT and EMIT before its result
// word is on the output. A border word takes a RAM read, then a write-back; the next word
// waits for the two squaring steps and the bit-serial square root after an interior word.
// The output register lets the next word be accepted while a result waits to be taken.
// Reset (synchronous, active low) restores 640x480, clears the counters and window, and
// empties the line-store fill count, so unwritten line-store entries read as zero.
`timescale 1ns / 1ps

module sobel_gradient_magnitude_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [sgm_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [sgm_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [sgm_pkg::PIX_W-1:0] o_magnitude,
    output logic [sgm_pkg::ROW_W-1:0] o_out_row,
    output logic [sgm_pkg::COL_W-1:0] o_out_col
);
    import sgm_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;
    logic [FILL_W-1:0] r_fill;
    logic [47:0]       r_win;
    logic [PIX_W-1:0]  r_pix;

    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic [SUM_W-1:0]         r_sum;
    logic [ROW_W-1:0]         r_res_row;
    logic [ADDR_W-1:0]        r_res_col;
    logic [ROOT_W-1:0]        r_mag;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_magnitude;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_col;

    logic               accept;
    logic               out_free;
    logic [LINE_W-1:0]  ram_rdata;
    logic               ram_we;
    logic               entry_valid;
    logic [PIX_W-1:0]   up_v;
    logic [PIX_W-1:0]   mid_v;
    logic [23:0]        cur;
    logic [WUSE_W-1:0]  w_use;
    logic [CFG_W-1:0]   h_use;
    logic               row_end;
    logic               produce;
    logic signed [GRAD_W-1:0]   gx_w;
    logic signed [GRAD_W-1:0]   gy_w;
    logic signed [2*GRAD_W-1:0] sq_x;
    logic signed [2*GRAD_W-1:0] sq_y;
    logic signed [GRAD_W-1:0]   e_top, e_mid, e_bot, l_top, l_mid, l_bot, c_top, c_bot;
    t_root_req root_req;
    t_root_rsp root_rsp;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Both line stores share one word: upper row in the high byte, lower row in the low byte.
    sgm_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata ({mid_v, r_pix}),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign ram_we = (r_state == S_READ);

    // Columns are written in ascending order from zero, so the written entries form a prefix.
    assign entry_valid = {1'b0, r_col} < r_fill;
    assign up_v        = entry_valid ? ram_rdata[LINE_W-1:PIX_W] : '0;
    assign mid_v       = entry_valid ? ram_rdata[PIX_W-1:0] : '0;
    assign cur         = {r_pix, mid_v, up_v};

    always_comb begin
        if (r_frame_width < MIN_DIM) begin
            w_use = WUSE_W'(MIN_DIM);
        end else if (WUSE_W'(r_frame_width) > WUSE_W'(MAX_WIDTH)) begin
            w_use = WUSE_W'(MAX_WIDTH);
        end else begin
            w_use = WUSE_W'(r_frame_width);
        end
        h_use = (r_frame_height < MIN_DIM) ? MIN_DIM : r_frame_height;
    end

    assign row_end = WUSE_W'(r_col) >= (w_use - WUSE_W'(1));
    assign produce = (r_row >= ROW_W'(2)) && (r_col >= ADDR_W'(2));

    // Window bytes: e_ is the new column, c_ the centre column, l_ the left column.
    always_comb begin
        e_top = $signed({4'b0, cur[7:0]});
        e_mid = $signed({4'b0, cur[15:8]});
        e_bot = $signed({4'b0, cur[23:16]});
        c_top = $signed({4'b0, r_win[7:0]});
        c_bot = $signed({4'b0, r_win[23:16]});
        l_top = $signed({4'b0, r_win[31:24]});
        l_mid = $signed({4'b0, r_win[39:32]});
        l_bot = $signed({4'b0, r_win[47:40]});
        gx_w  = (e_top - l_top) + ((e_mid - l_mid) <<< 1) + (e_bot - l_bot);
        gy_w  = (l_bot + (c_bot <<< 1) + e_bot) - (l_top + (c_top <<< 1) + e_top);
    end

    assign sq_x = r_gx * r_gx;
    assign sq_y = r_gy * r_gy;

    assign root_req.start = (r_state == S_SQY);
    assign root_req.sum   = r_sum + sq_y[SUM_W-1:0];

    sgm_isqrt u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (root_req),
        .o_rsp   (root_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = produce ? S_SQX : S_IDLE;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_ROOT;
            S_ROOT: begin
                if (root_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_fill         <= '0;
            r_win          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_READ) begin
                r_win <= {r_win[23:0], cur};
                if (!entry_valid) begin
                    r_fill <= FILL_W'(r_col) + FILL_W'(1);
                end
                if (row_end) begin
                    r_col <= '0;
                    r_row <= (CFG_W'(r_row) >= h_use - CFG_W'(1)) ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + ADDR_W'(1);
                end
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_pixel;
        end
        if (r_state == S_READ) begin
            r_gx      <= gx_w;
            r_gy      <= gy_w;
            r_res_row <= r_row - ROW_W'(1);
            r_res_col <= r_col - ADDR_W'(1);
        end
        if (r_state == S_SQX) begin
            r_sum <= sq_x[SUM_W-1:0];
        end
        if (r_state == S_ROOT && root_rsp.done) begin
            r_mag <= root_rsp.root;
        end
        if (r_state == S_EMIT && out_free) begin
            r_magnitude <= r_mag;
            r_out_row   <= r_res_row;
            r_out_col   <= COL_W'(r_res_col);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_magnitude = r_magnitude;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;

endmodule
